>>> hdl/u2hps_pkg.sv
// Shared types, codes and constants of the USB 2.0 hub port status engine.
// Depends on nothing; every other file refers to it by scoped names.
package u2hps_pkg;

	localparam int MAX_PORTS_DEF = 8;
	localparam int QUEUE_DEPTH   = 8;

	// request and event codes
	localparam logic [3:0] FN_PORT_STATUS = 4'd0;
	localparam logic [3:0] FN_SET_FEATURE = 4'd1;
	localparam logic [3:0] FN_CLR_FEATURE = 4'd2;
	localparam logic [3:0] FN_HUB_STATUS  = 4'd3;
	localparam logic [3:0] FN_HUB_FEATURE = 4'd4;
	localparam logic [3:0] FN_CHANGE_POLL = 4'd5;
	localparam logic [3:0] FN_CANCEL_POLL = 4'd6;
	localparam logic [3:0] FN_ATTACH      = 4'd7;
	localparam logic [3:0] FN_HUB_RESET   = 4'd8;
	localparam logic [3:0] FN_FIND_FREE   = 4'd9;

	// port feature selectors
	localparam logic [15:0] SEL_PORT_ENABLE    = 16'd1;
	localparam logic [15:0] SEL_PORT_SUSPEND   = 16'd2;
	localparam logic [15:0] SEL_PORT_RESET     = 16'd4;
	localparam logic [15:0] SEL_PORT_POWER     = 16'd8;
	localparam logic [15:0] SEL_C_CONNECTION   = 16'd16;
	localparam logic [15:0] SEL_C_ENABLE       = 16'd17;
	localparam logic [15:0] SEL_C_SUSPEND      = 16'd18;
	localparam logic [15:0] SEL_C_OVERCURRENT  = 16'd19;
	localparam logic [15:0] SEL_C_RESET        = 16'd20;
	localparam logic [15:0] SEL_PORT_INDICATOR = 16'd22;

	// wPortStatus bits
	localparam logic [10:0] ST_CONNECTION = 11'h001;
	localparam logic [10:0] ST_ENABLE     = 11'h002;
	localparam logic [10:0] ST_SUSPEND    = 11'h004;
	localparam logic [10:0] ST_POWER      = 11'h100;
	localparam logic [10:0] ST_LOW_SPEED  = 11'h200;
	localparam logic [10:0] ST_HIGH_SPEED = 11'h400;

	// wPortChange bits
	localparam logic [4:0] CH_CONNECTION  = 5'h01;
	localparam logic [4:0] CH_ENABLE      = 5'h02;
	localparam logic [4:0] CH_SUSPEND     = 5'h04;
	localparam logic [4:0] CH_OVERCURRENT = 5'h08;
	localparam logic [4:0] CH_RESET       = 5'h10;

	// result status codes
	localparam logic [1:0] RS_OK      = 2'd0;
	localparam logic [1:0] RS_STALL   = 2'd1;
	localparam logic [1:0] RS_HELD    = 2'd2;
	localparam logic [1:0] RS_REFUSED = 2'd3;

	// device speeds
	localparam logic [1:0] SPD_LOW   = 2'd0;
	localparam logic [1:0] SPD_FULL  = 2'd1;
	localparam logic [1:0] SPD_HIGH  = 2'd2;
	localparam logic [1:0] SPD_SUPER = 2'd3;

	localparam logic [2:0] STATUS_BYTES = 3'd4;

	typedef struct packed {
		logic [3:0]  func;
		logic [7:0]  port;
		logic [15:0] feature;
		logic [15:0] req_length;
		logic [1:0]  device_speed;
	} item_t;

	typedef struct packed {
		logic [1:0]  result_status;
		logic [10:0] port_status_word;
		logic [4:0]  port_change_word;
		logic [15:0] change_bitmap;
		logic [2:0]  data_length;
		logic [3:0]  free_port;
		logic        from_held_poll;
		logic        last;
	} result_t;

	typedef struct packed {
		logic push;
		logic dbl;
	} push_t;

endpackage

>>> hdl/u2hps_core.sv
// Per-port status, change, presence and speed registers plus the request
// decoder that updates them. Depends on u2hps_pkg.
module u2hps_core #(
	parameter int MAX_PORTS = u2hps_pkg::MAX_PORTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_data,
	input  logic               item_valid,
	input  u2hps_pkg::item_t   item,
	output u2hps_pkg::push_t   ctl,
	output u2hps_pkg::result_t r0,
	output u2hps_pkg::result_t r1
);

	logic [10:0] stat_q [MAX_PORTS];
	logic [4:0]  chg_q  [MAX_PORTS];
	logic [1:0]  spd_q  [MAX_PORTS];
	logic [MAX_PORTS-1:0] pres_q;
	logic        held_q;
	logic [3:0]  count_q;

	logic [10:0] stat_nx [MAX_PORTS];
	logic [4:0]  chg_nx  [MAX_PORTS];
	logic [1:0]  spd_nx  [MAX_PORTS];
	logic [MAX_PORTS-1:0] pres_nx;
	logic        held_nx;

	logic [3:0]  served;
	logic [MAX_PORTS-1:0] srv, sel;
	logic        inrange;
	logic [10:0] rd_stat, new_stat;
	logic [4:0]  rd_chg, new_chg;
	logic [1:0]  rd_spd;
	logic        rd_pres;
	logic        wr_port, hub_rst, complete;
	logic [15:0] map, cur_map;
	logic [2:0]  map_bytes, short_len;
	logic [3:0]  fp;
	u2hps_pkg::result_t fin;

	assign served = (count_q > 4'(MAX_PORTS)) ? 4'(MAX_PORTS) : count_q;
	assign inrange = (item.port != 8'd0) && (item.port <= {4'd0, served});
	assign map_bytes = (served >= 4'd8) ? 3'd2 : 3'd1;
	assign short_len = (item.req_length < 16'd4) ? item.req_length[2:0]
	                                             : u2hps_pkg::STATUS_BYTES;

	always_comb begin
		rd_stat = '0;
		rd_chg  = '0;
		rd_spd  = '0;
		rd_pres = 1'b0;
		fp      = '0;
		cur_map = '0;
		for (int i = 0; i < MAX_PORTS; i++) begin
			srv[i] = (4'(i) < served);
			sel[i] = inrange && (item.port == 8'(i + 1));
			cur_map[i + 1] = srv[i] && (chg_q[i] != 5'd0);
			if (sel[i]) begin
				rd_stat = rd_stat | stat_q[i];
				rd_chg  = rd_chg | chg_q[i];
				rd_spd  = rd_spd | spd_q[i];
				rd_pres = rd_pres | pres_q[i];
			end
		end
		for (int i = MAX_PORTS - 1; i >= 0; i--) begin
			if (srv[i] && !pres_q[i]) begin
				fp = 4'(i + 1);
			end
		end
		if (item.device_speed == u2hps_pkg::SPD_SUPER) begin
			fp = '0;
		end
	end

	// decode one request against the selected port
	always_comb begin
		wr_port  = 1'b0;
		hub_rst  = 1'b0;
		complete = 1'b0;
		new_stat = rd_stat;
		new_chg  = rd_chg;
		held_nx  = held_q;
		fin      = '0;
		fin.last = 1'b1;
		fin.result_status = u2hps_pkg::RS_OK;
		case (item.func)
			u2hps_pkg::FN_PORT_STATUS: begin
				if (inrange) begin
					fin.port_status_word = rd_stat;
					fin.port_change_word = rd_chg;
					fin.data_length = short_len;
				end else begin
					fin.result_status = u2hps_pkg::RS_STALL;
				end
			end
			u2hps_pkg::FN_SET_FEATURE: begin
				if (!inrange) begin
					fin.result_status = u2hps_pkg::RS_STALL;
				end else if (item.feature == u2hps_pkg::SEL_PORT_RESET) begin
					if (rd_pres) begin
						wr_port = 1'b1;
						new_stat = (rd_stat | u2hps_pkg::ST_ENABLE) &
						           ~(u2hps_pkg::ST_LOW_SPEED | u2hps_pkg::ST_HIGH_SPEED |
						             u2hps_pkg::ST_SUSPEND);
						if (rd_spd == u2hps_pkg::SPD_LOW) begin
							new_stat = new_stat | u2hps_pkg::ST_LOW_SPEED;
						end else if (rd_spd == u2hps_pkg::SPD_HIGH) begin
							new_stat = new_stat | u2hps_pkg::ST_HIGH_SPEED;
						end
						new_chg = rd_chg | u2hps_pkg::CH_RESET;
						complete = held_q;
					end
				end else if (item.feature == u2hps_pkg::SEL_PORT_POWER) begin
					wr_port = 1'b1;
					new_stat = rd_stat | u2hps_pkg::ST_POWER;
				end else if (item.feature == u2hps_pkg::SEL_PORT_SUSPEND) begin
					wr_port = 1'b1;
					new_stat = rd_stat | u2hps_pkg::ST_SUSPEND;
				end else if (item.feature != u2hps_pkg::SEL_PORT_INDICATOR) begin
					fin.result_status = u2hps_pkg::RS_STALL;
				end
			end
			u2hps_pkg::FN_CLR_FEATURE: begin
				if (!inrange) begin
					fin.result_status = u2hps_pkg::RS_STALL;
				end else begin
					wr_port = 1'b1;
					case (item.feature)
						u2hps_pkg::SEL_PORT_ENABLE:    new_stat = rd_stat & ~u2hps_pkg::ST_ENABLE;
						u2hps_pkg::SEL_PORT_SUSPEND:   new_stat = rd_stat & ~u2hps_pkg::ST_SUSPEND;
						u2hps_pkg::SEL_PORT_POWER:     new_stat = rd_stat & ~u2hps_pkg::ST_POWER;
						u2hps_pkg::SEL_PORT_INDICATOR: new_stat = rd_stat;
						u2hps_pkg::SEL_C_CONNECTION:   new_chg = rd_chg & ~u2hps_pkg::CH_CONNECTION;
						u2hps_pkg::SEL_C_ENABLE:       new_chg = rd_chg & ~u2hps_pkg::CH_ENABLE;
						u2hps_pkg::SEL_C_SUSPEND:      new_chg = rd_chg & ~u2hps_pkg::CH_SUSPEND;
						u2hps_pkg::SEL_C_OVERCURRENT:  new_chg = rd_chg & ~u2hps_pkg::CH_OVERCURRENT;
						u2hps_pkg::SEL_C_RESET:        new_chg = rd_chg & ~u2hps_pkg::CH_RESET;
						default: begin
							wr_port = 1'b0;
							fin.result_status = u2hps_pkg::RS_STALL;
						end
					endcase
				end
			end
			u2hps_pkg::FN_HUB_STATUS: begin
				fin.data_length = short_len;
			end
			u2hps_pkg::FN_HUB_FEATURE: begin
				fin.result_status = u2hps_pkg::RS_OK;
			end
			u2hps_pkg::FN_CHANGE_POLL: begin
				if (cur_map != 16'd0) begin
					fin.change_bitmap = cur_map;
					fin.data_length = map_bytes;
				end else if (held_q) begin
					fin.result_status = u2hps_pkg::RS_STALL;
				end else begin
					held_nx = 1'b1;
					fin.result_status = u2hps_pkg::RS_HELD;
				end
			end
			u2hps_pkg::FN_CANCEL_POLL: begin
				held_nx = 1'b0;
			end
			u2hps_pkg::FN_ATTACH: begin
				if (!inrange || item.device_speed == u2hps_pkg::SPD_SUPER || rd_pres) begin
					fin.result_status = u2hps_pkg::RS_REFUSED;
				end else begin
					wr_port = 1'b1;
					new_stat = rd_stat | u2hps_pkg::ST_CONNECTION;
					new_chg = rd_chg | u2hps_pkg::CH_CONNECTION;
					complete = held_q;
				end
			end
			u2hps_pkg::FN_HUB_RESET: begin
				hub_rst = 1'b1;
				held_nx = 1'b0;
			end
			u2hps_pkg::FN_FIND_FREE: begin
				fin.free_port = fp;
			end
			default: begin
				fin.result_status = u2hps_pkg::RS_STALL;
			end
		endcase
		if (complete) begin
			held_nx = 1'b0;
		end
	end

	// next per-port state; the bitmap reflects changes raised by this request
	always_comb begin
		map = '0;
		for (int i = 0; i < MAX_PORTS; i++) begin
			stat_nx[i] = stat_q[i];
			chg_nx[i]  = chg_q[i];
			spd_nx[i]  = spd_q[i];
			pres_nx[i] = pres_q[i];
			if (hub_rst && srv[i]) begin
				stat_nx[i] = u2hps_pkg::ST_POWER |
				             (pres_q[i] ? u2hps_pkg::ST_CONNECTION : 11'd0);
				chg_nx[i] = pres_q[i] ? u2hps_pkg::CH_CONNECTION : 5'd0;
			end else if (wr_port && sel[i]) begin
				stat_nx[i] = new_stat;
				chg_nx[i] = new_chg;
				if (item.func == u2hps_pkg::FN_ATTACH) begin
					pres_nx[i] = 1'b1;
					spd_nx[i] = item.device_speed;
				end
			end
			map[i + 1] = srv[i] && (chg_nx[i] != 5'd0);
		end
	end

	always_comb begin
		ctl.push = item_valid;
		ctl.dbl  = item_valid && complete;
		r1 = fin;
		if (complete) begin
			r0 = '0;
			r0.result_status = u2hps_pkg::RS_OK;
			r0.change_bitmap = map;
			r0.data_length = map_bytes;
			r0.from_held_poll = 1'b1;
		end else begin
			r0 = fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PORTS; i++) begin
				stat_q[i] <= u2hps_pkg::ST_POWER;
				chg_q[i]  <= '0;
				spd_q[i]  <= '0;
			end
			pres_q  <= '0;
			held_q  <= 1'b0;
			count_q <= 4'd8;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_data;
			end
			if (item_valid) begin
				for (int i = 0; i < MAX_PORTS; i++) begin
					stat_q[i] <= stat_nx[i];
					chg_q[i]  <= chg_nx[i];
					spd_q[i]  <= spd_nx[i];
				end
				pres_q <= pres_nx;
				held_q <= held_nx;
			end
		end
	end

endmodule

>>> hdl/u2hps_queue.sv
// Result queue: takes one or two results per cycle, hands out one per beat.
// Depends on u2hps_pkg.
module u2hps_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  u2hps_pkg::push_t   ctl,
	input  u2hps_pkg::result_t r0,
	input  u2hps_pkg::result_t r1,
	input  logic               pop,
	output logic               nonempty,
	output logic               nearly_full,
	output u2hps_pkg::result_t head
);

	localparam int PW = $clog2(u2hps_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(u2hps_pkg::QUEUE_DEPTH + 1);

	u2hps_pkg::result_t mem_q [u2hps_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] push_n;

	assign push_n = ctl.push ? (ctl.dbl ? CW'(2) : CW'(1)) : CW'(0);
	assign nonempty = (count_q != '0);
	// leave room for the request in the input register and one more behind it
	assign nearly_full = (count_q > CW'(u2hps_pkg::QUEUE_DEPTH - 4));
	assign head = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[wptr_q] <= r0;
		end
		if (ctl.dbl) begin
			mem_q[wptr_q + PW'(1)] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + PW'(push_n);
			rptr_q  <= rptr_q + PW'(pop);
			count_q <= count_q + push_n - CW'(pop);
		end
	end

endmodule

>>> hdl/usb2_hub_port_status_engine_top.sv
// USB 2.0 hub port status engine: accepts one request or event per beat.
// The first result passes through the input register and then the result queue before it shows.
// Throughput: one item per cycle while at most four results wait in the eight-entry queue.
// A held-poll completion adds a second result for the same item.
// Reset (arst_n low, asynchronous): ports powered, no devices, eight ports served, queue empty.
// Depends on u2hps_pkg, u2hps_core and u2hps_queue.
module usb2_hub_port_status_engine_top #(
	parameter int MAX_PORTS = u2hps_pkg::MAX_PORTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel: number of served ports
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  func,
	input  logic [7:0]  port,
	input  logic [15:0] feature,
	input  logic [15:0] req_length,
	input  logic [1:0]  device_speed,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_status,
	output logic [10:0] port_status_word,
	output logic [4:0]  port_change_word,
	output logic [15:0] change_bitmap,
	output logic [2:0]  data_length,
	output logic [3:0]  free_port,
	output logic        from_held_poll,
	output logic        last
);

	u2hps_pkg::item_t   item_s1;
	logic               valid_s1;
	u2hps_pkg::push_t   ctl;
	u2hps_pkg::result_t r0, r1, head;
	logic               nearly_full;
	logic               accept;

	// the register is always writable; the user must write it only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	// stall on queue level alone, so the in-flight item always finds room
	assign in_stall = nearly_full;
	assign accept = in_valid && !in_stall;

	// input register: hold the accepted beat for decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.func         <= func;
			item_s1.port         <= port;
			item_s1.feature      <= feature;
			item_s1.req_length   <= req_length;
			item_s1.device_speed <= device_speed;
		end
	end

	// decode against port state; state advances on the same edge as the push
	u2hps_core #(
		.MAX_PORTS(MAX_PORTS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.item_valid(valid_s1),
		.item      (item_s1),
		.ctl       (ctl),
		.r0        (r0),
		.r1        (r1)
	);

	// result register file: drop a beat at the head on each accepted output
	u2hps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.r0         (r0),
		.r1         (r1),
		.pop        (out_valid && !out_stall),
		.nonempty   (out_valid),
		.nearly_full(nearly_full),
		.head       (head)
	);

	assign result_status    = head.result_status;
	assign port_status_word = head.port_status_word;
	assign port_change_word = head.port_change_word;
	assign change_bitmap    = head.change_bitmap;
	assign data_length      = head.data_length;
	assign free_port        = head.free_port;
	assign from_held_poll   = head.from_held_poll;
	assign last             = head.last;

endmodule

>>> hdl/u2hps_checker.sv
// Port-level checker for the hub port status engine, bound to the top level.
// Depends on u2hps_pkg for result codes.
module u2hps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  result_status,
	input logic [15:0] change_bitmap,
	input logic [2:0]  data_length,
	input logic        from_held_poll,
	input logic        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_first_is_completion: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> from_held_poll && result_status == u2hps_pkg::RS_OK)
		else $error("non-final result is not a held poll completion");

	a_completion_map: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && from_held_poll |-> change_bitmap != 16'd0 && !change_bitmap[0]
		&& !last && (data_length == 3'd1 || data_length == 3'd2))
		else $error("held poll completion carries a bad bitmap");

	a_held_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_status == u2hps_pkg::RS_HELD |->
		change_bitmap == 16'd0 && data_length == 3'd0 && last)
		else $error("held poll result carries data");

endmodule

bind usb2_hub_port_status_engine_top u2hps_checker u_checker (.*);

>>> sim/usb2_hub_port_status_engine_top_test.sv
// Self-checking bench for usb2_hub_port_status_engine_top: hub requests, port events
// and change polls are driven with random gaps and checked against a port-state predictor.
// Depends on u2hps_pkg and the engine RTL only.
module usb2_hub_port_status_engine_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 3;
	localparam int IDLE_PCT      = 35;     // chance of a gap on either side
	localparam int HOLD_CYCLES   = 120;    // long receiver hold-off
	localparam int SETTLE_CYCLES = 8;      // pipeline drain plus margin
	localparam int QUIET_LIMIT   = 4000;   // cycles with no beat on any channel
	localparam int PHASE_ITEMS   = 305;
	localparam int REPORT_LIMIT  = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  func = '0;
	logic [7:0]  port = '0;
	logic [15:0] feature = '0;
	logic [15:0] req_length = '0;
	logic [1:0]  device_speed = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_status;
	logic [10:0] port_status_word;
	logic [4:0]  port_change_word;
	logic [15:0] change_bitmap;
	logic [2:0]  data_length;
	logic [3:0]  free_port;
	logic        from_held_poll;
	logic        last;

	usb2_hub_port_status_engine_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.port             (port),
		.feature          (feature),
		.req_length       (req_length),
		.device_speed     (device_speed),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_status    (result_status),
		.port_status_word (port_status_word),
		.port_change_word (port_change_word),
		.change_bitmap    (change_bitmap),
		.data_length      (data_length),
		.free_port        (free_port),
		.from_held_poll   (from_held_poll),
		.last             (last)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Predicted hub state, mirrored beat by beat on accepted requests.
	logic [3:0]  hub_ports_cfg = 4'd8;
	logic [10:0] port_stat [u2hps_pkg::MAX_PORTS_DEF];
	logic [4:0]  port_chg [u2hps_pkg::MAX_PORTS_DEF];
	bit          dev_present [u2hps_pkg::MAX_PORTS_DEF];
	logic [1:0]  dev_speed [u2hps_pkg::MAX_PORTS_DEF];
	bit          poll_pending = 1'b0;

	u2hps_pkg::item_t   pending_requests [$];
	u2hps_pkg::result_t awaited_results [$];
	u2hps_pkg::item_t   beat;

	int          mismatches = 0;
	int unsigned quiet_cycles = 0;
	int          hold_left = 0;
	bit          want_long_hold = 1'b0;
	bit          steady = 1'b0;

	// Ports actually served: the register saturates at the build size.
	function automatic int served_ports();
		return (hub_ports_cfg > u2hps_pkg::MAX_PORTS_DEF) ? u2hps_pkg::MAX_PORTS_DEF
			: int'(hub_ports_cfg);
	endfunction

	// Bit n marks a change pending on port n; bit 0 stays clear.
	function automatic logic [15:0] pending_change_map();
		logic [15:0] m;
		m = '0;
		for (int i = 0; i < served_ports(); i++)
			if (port_chg[i] != '0)
				m[i + 1] = 1'b1;
		return m;
	endfunction

	function automatic logic [2:0] bitmap_bytes();
		return 3'((served_ports() + 8) / 8);
	endfunction

	task automatic expect_result(input logic [1:0] rs, input logic [10:0] psw,
			input logic [4:0] pcw, input logic [15:0] map, input logic [2:0] len,
			input logic [3:0] fp, input logic held_done, input logic fin);
		u2hps_pkg::result_t r;
		r.result_status    = rs;
		r.port_status_word = psw;
		r.port_change_word = pcw;
		r.change_bitmap    = map;
		r.data_length      = len;
		r.free_port        = fp;
		r.from_held_poll   = held_done;
		r.last             = fin;
		awaited_results.push_back(r);
	endtask

	// Advance the predicted state by one request and queue the results it causes.
	task automatic apply_request(input u2hps_pkg::item_t rq);
		int          n, p;
		bit          hit, raise;
		logic [1:0]  rs;
		logic [10:0] s, o_psw;
		logic [4:0]  o_pcw;
		logic [15:0] o_map;
		logic [2:0]  o_len;
		logic [3:0]  o_fp;
		n = served_ports();
		hit = rq.port >= 1 && int'(rq.port) <= n;
		p = hit ? int'(rq.port) - 1 : 0;
		raise = 1'b0;
		rs = u2hps_pkg::RS_OK;
		o_psw = '0;
		o_pcw = '0;
		o_map = '0;
		o_len = '0;
		o_fp = '0;
		case (rq.func)
		u2hps_pkg::FN_PORT_STATUS: begin
			if (hit) begin
				o_psw = port_stat[p];
				o_pcw = port_chg[p];
				o_len = (rq.req_length < u2hps_pkg::STATUS_BYTES) ? rq.req_length[2:0]
					: u2hps_pkg::STATUS_BYTES;
			end else
				rs = u2hps_pkg::RS_STALL;
		end
		u2hps_pkg::FN_SET_FEATURE: begin
			if (!hit)
				rs = u2hps_pkg::RS_STALL;
			else if (rq.feature == u2hps_pkg::SEL_PORT_RESET) begin
				// reset finishes at once; speed bits follow the attached device
				if (dev_present[p]) begin
					s = port_stat[p] | u2hps_pkg::ST_ENABLE;
					s &= ~(u2hps_pkg::ST_LOW_SPEED | u2hps_pkg::ST_HIGH_SPEED |
						u2hps_pkg::ST_SUSPEND);
					if (dev_speed[p] == u2hps_pkg::SPD_LOW)
						s |= u2hps_pkg::ST_LOW_SPEED;
					else if (dev_speed[p] == u2hps_pkg::SPD_HIGH)
						s |= u2hps_pkg::ST_HIGH_SPEED;
					port_stat[p] = s;
					port_chg[p] |= u2hps_pkg::CH_RESET;
					raise = 1'b1;
				end
			end else if (rq.feature == u2hps_pkg::SEL_PORT_POWER)
				port_stat[p] |= u2hps_pkg::ST_POWER;
			else if (rq.feature == u2hps_pkg::SEL_PORT_SUSPEND)
				port_stat[p] |= u2hps_pkg::ST_SUSPEND;
			else if (rq.feature != u2hps_pkg::SEL_PORT_INDICATOR)
				rs = u2hps_pkg::RS_STALL;
		end
		u2hps_pkg::FN_CLR_FEATURE: begin
			if (!hit)
				rs = u2hps_pkg::RS_STALL;
			else begin
				case (rq.feature)
				u2hps_pkg::SEL_PORT_ENABLE:    port_stat[p] &= ~u2hps_pkg::ST_ENABLE;
				u2hps_pkg::SEL_PORT_SUSPEND:   port_stat[p] &= ~u2hps_pkg::ST_SUSPEND;
				u2hps_pkg::SEL_PORT_POWER:     port_stat[p] &= ~u2hps_pkg::ST_POWER;
				u2hps_pkg::SEL_PORT_INDICATOR: ;
				u2hps_pkg::SEL_C_CONNECTION:   port_chg[p] &= ~u2hps_pkg::CH_CONNECTION;
				u2hps_pkg::SEL_C_ENABLE:       port_chg[p] &= ~u2hps_pkg::CH_ENABLE;
				u2hps_pkg::SEL_C_SUSPEND:      port_chg[p] &= ~u2hps_pkg::CH_SUSPEND;
				u2hps_pkg::SEL_C_OVERCURRENT:  port_chg[p] &= ~u2hps_pkg::CH_OVERCURRENT;
				u2hps_pkg::SEL_C_RESET:        port_chg[p] &= ~u2hps_pkg::CH_RESET;
				default:                       rs = u2hps_pkg::RS_STALL;
				endcase
			end
		end
		u2hps_pkg::FN_HUB_STATUS:
			o_len = (rq.req_length < u2hps_pkg::STATUS_BYTES) ? rq.req_length[2:0]
				: u2hps_pkg::STATUS_BYTES;
		u2hps_pkg::FN_HUB_FEATURE: ;
		u2hps_pkg::FN_CHANGE_POLL: begin
			// answer now if anything changed, else park it; only one may be parked
			if (pending_change_map() != '0) begin
				o_map = pending_change_map();
				o_len = bitmap_bytes();
			end else if (poll_pending)
				rs = u2hps_pkg::RS_STALL;
			else begin
				poll_pending = 1'b1;
				rs = u2hps_pkg::RS_HELD;
			end
		end
		u2hps_pkg::FN_CANCEL_POLL:
			poll_pending = 1'b0;
		u2hps_pkg::FN_ATTACH: begin
			if (!hit || rq.device_speed == u2hps_pkg::SPD_SUPER || dev_present[p])
				rs = u2hps_pkg::RS_REFUSED;
			else begin
				dev_present[p] = 1'b1;
				dev_speed[p] = rq.device_speed;
				port_stat[p] |= u2hps_pkg::ST_CONNECTION;
				port_chg[p] |= u2hps_pkg::CH_CONNECTION;
				raise = 1'b1;
			end
		end
		u2hps_pkg::FN_HUB_RESET: begin
			// devices stay; served ports drop back to power, plus connection where a device is attached
			poll_pending = 1'b0;
			for (int i = 0; i < n; i++) begin
				port_stat[i] = u2hps_pkg::ST_POWER;
				port_chg[i] = '0;
				if (dev_present[i]) begin
					port_stat[i] |= u2hps_pkg::ST_CONNECTION;
					port_chg[i] |= u2hps_pkg::CH_CONNECTION;
				end
			end
		end
		u2hps_pkg::FN_FIND_FREE: begin
			if (rq.device_speed != u2hps_pkg::SPD_SUPER)
				for (int i = 0; i < n; i++)
					if (!dev_present[i] && o_fp == '0)
						o_fp = 4'(i + 1);
		end
		default:
			rs = u2hps_pkg::RS_STALL;
		endcase
		// a new change releases a parked poll ahead of the request's own answer
		if (raise && poll_pending && pending_change_map() != '0) begin
			poll_pending = 1'b0;
			expect_result(u2hps_pkg::RS_OK, '0, '0, pending_change_map(), bitmap_bytes(),
				'0, 1'b1, 1'b0);
		end
		expect_result(rs, o_psw, o_pcw, o_map, o_len, o_fp, 1'b0, 1'b1);
	endtask

	task automatic queue_request(input logic [3:0] f, input logic [7:0] pn,
			input logic [15:0] sel, input logic [15:0] len, input logic [1:0] spd);
		u2hps_pkg::item_t it;
		it.func = f;
		it.port = pn;
		it.feature = sel;
		it.req_length = len;
		it.device_speed = spd;
		pending_requests.push_back(it);
	endtask

	// Mostly well-formed requests on real ports and known selectors, some noise.
	function automatic u2hps_pkg::item_t draw_request();
		u2hps_pkg::item_t it;
		int               r;
		r = $urandom_range(0, 99);
		if (r < 12)      it.func = u2hps_pkg::FN_PORT_STATUS;
		else if (r < 27) it.func = u2hps_pkg::FN_SET_FEATURE;
		else if (r < 45) it.func = u2hps_pkg::FN_CLR_FEATURE;
		else if (r < 50) it.func = u2hps_pkg::FN_HUB_STATUS;
		else if (r < 53) it.func = u2hps_pkg::FN_HUB_FEATURE;
		else if (r < 63) it.func = u2hps_pkg::FN_CHANGE_POLL;
		else if (r < 67) it.func = u2hps_pkg::FN_CANCEL_POLL;
		else if (r < 80) it.func = u2hps_pkg::FN_ATTACH;
		else if (r < 84) it.func = u2hps_pkg::FN_HUB_RESET;
		else if (r < 94) it.func = u2hps_pkg::FN_FIND_FREE;
		else             it.func = u2hps_pkg::FN_FIND_FREE + 4'($urandom_range(1, 6));
		it.port = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(1, 9))
			: 8'($urandom_range(0, 255));
		it.feature = 16'($urandom);
		if (it.func == u2hps_pkg::FN_SET_FEATURE) begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3: it.feature = u2hps_pkg::SEL_PORT_RESET;
			4:          it.feature = u2hps_pkg::SEL_PORT_POWER;
			5:          it.feature = u2hps_pkg::SEL_PORT_SUSPEND;
			6:          it.feature = u2hps_pkg::SEL_PORT_INDICATOR;
			7:          it.feature = u2hps_pkg::SEL_PORT_ENABLE;
			default:    ;
			endcase
		end else if (it.func == u2hps_pkg::FN_CLR_FEATURE) begin
			case ($urandom_range(0, 10))
			0:       it.feature = u2hps_pkg::SEL_PORT_ENABLE;
			1:       it.feature = u2hps_pkg::SEL_PORT_SUSPEND;
			2:       it.feature = u2hps_pkg::SEL_PORT_POWER;
			3:       it.feature = u2hps_pkg::SEL_PORT_INDICATOR;
			4:       it.feature = u2hps_pkg::SEL_C_CONNECTION;
			5:       it.feature = u2hps_pkg::SEL_C_ENABLE;
			6:       it.feature = u2hps_pkg::SEL_C_SUSPEND;
			7:       it.feature = u2hps_pkg::SEL_C_OVERCURRENT;
			8, 9:    it.feature = u2hps_pkg::SEL_C_RESET;
			default: ;
			endcase
		end
		it.req_length = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 6))
			: 16'($urandom_range(0, 65535));
		it.device_speed = 2'($urandom_range(0, 3));
		return it;
	endfunction

	// Write the served-port count through its own channel; hold the beat until taken.
	task automatic write_hub_ports(input logic [3:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		hub_ports_cfg = value;
	endtask

	// Block until every queued request went in and every result came back.
	task automatic wait_drained();
		while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Request driver: predict on each accepted beat, hold a stalled beat,
	// otherwise offer the next request or idle at random.
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			apply_request(beat);
		if (!in_valid || !in_stall) begin
			if (pending_requests.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
				beat = pending_requests.pop_front();
				func <= beat.func;
				port <= beat.port;
				feature <= beat.feature;
				req_length <= beat.req_length;
				device_speed <= beat.device_speed;
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%s: expected %0h, got %0h", name, want, got);
		end
	endtask

	// Result monitor: compare each accepted beat with the oldest expectation,
	// then pick the next stall (long hold-off, random gaps, or none).
	always @(posedge clk) begin
		u2hps_pkg::result_t w;
		if (out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result beat: status %0d last %0b",
						result_status, last);
			end else begin
				w = awaited_results.pop_front();
				check_field("result_status", 16'(w.result_status), 16'(result_status));
				check_field("port_status_word", 16'(w.port_status_word),
					16'(port_status_word));
				check_field("port_change_word", 16'(w.port_change_word),
					16'(port_change_word));
				check_field("change_bitmap", w.change_bitmap, change_bitmap);
				check_field("data_length", 16'(w.data_length), 16'(data_length));
				check_field("free_port", 16'(w.free_port), 16'(free_port));
				check_field("from_held_poll", 16'(w.from_held_poll), 16'(from_held_poll));
				check_field("last", 16'(w.last), 16'(last));
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (want_long_hold) begin
			want_long_hold = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Watchdog: drop the run if no channel moves a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("usb2_hub_port_status_engine_top: mismatch");
				$finish;
			end
		end
	end

	initial begin
		logic [3:0] phase_counts [6];
		phase_counts = '{4'd1, 4'd0, 4'd3, 4'd5, 4'd15, 4'd8};
		for (int i = 0; i < u2hps_pkg::MAX_PORTS_DEF; i++) begin
			port_stat[i] = u2hps_pkg::ST_POWER;
			port_chg[i] = '0;
			dev_present[i] = 1'b0;
			dev_speed[i] = u2hps_pkg::SPD_LOW;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed pass at the reset port count of eight.
		queue_request(u2hps_pkg::FN_PORT_STATUS, 8'd1, '0, 16'd0, u2hps_pkg::SPD_LOW);
		queue_request(u2hps_pkg::FN_PORT_STATUS, 8'd0, 16'hFFFF, 16'hFFFF,
			u2hps_pkg::SPD_SUPER);                                        // port zero
		queue_request(u2hps_pkg::FN_CHANGE_POLL, 8'd1, '0, '0,
			u2hps_pkg::SPD_LOW);                                          // park
		queue_request(u2hps_pkg::FN_CHANGE_POLL, 8'd1, '0, '0,
			u2hps_pkg::SPD_LOW);                                          // second poll stalls while one is parked
		queue_request(u2hps_pkg::FN_ATTACH, 8'd1, '0, '0,
			u2hps_pkg::SPD_LOW);                                          // releases the poll
		queue_request(u2hps_pkg::FN_ATTACH, 8'd1, '0, '0, u2hps_pkg::SPD_FULL);   // occupied
		queue_request(u2hps_pkg::FN_ATTACH, 8'd8, '0, '0, u2hps_pkg::SPD_SUPER);  // super speed
		queue_request(u2hps_pkg::FN_ATTACH, 8'hFF, '0, '0,
			u2hps_pkg::SPD_HIGH);                                         // beyond served ports
		queue_request(u2hps_pkg::FN_ATTACH, 8'd8, '0, '0, u2hps_pkg::SPD_HIGH);
		queue_request(u2hps_pkg::FN_SET_FEATURE, 8'd8, u2hps_pkg::SEL_PORT_RESET, '0,
			u2hps_pkg::SPD_LOW);
		queue_request(u2hps_pkg::FN_SET_FEATURE, 8'd3, u2hps_pkg::SEL_PORT_RESET, '0,
			u2hps_pkg::SPD_LOW);                                          // no device
		queue_request(u2hps_pkg::FN_SET_FEATURE, 8'd1, u2hps_pkg::SEL_PORT_SUSPEND, '0,
			u2hps_pkg::SPD_LOW);
		queue_request(u2hps_pkg::FN_CLR_FEATURE, 8'd8, u2hps_pkg::SEL_PORT_POWER, '0,
			u2hps_pkg::SPD_LOW);
		queue_request(u2hps_pkg::FN_SET_FEATURE, 8'd1, u2hps_pkg::SEL_PORT_INDICATOR, '0,
			u2hps_pkg::SPD_LOW);
		queue_request(u2hps_pkg::FN_SET_FEATURE, 8'd1, 16'hFFFF, '0,
			u2hps_pkg::SPD_LOW);                                          // unknown selector
		queue_request(u2hps_pkg::FN_CLR_FEATURE, 8'd1, u2hps_pkg::SEL_PORT_ENABLE, '0,
			u2hps_pkg::SPD_LOW);
		queue_request(u2hps_pkg::FN_CLR_FEATURE, 8'd1, u2hps_pkg::SEL_C_CONNECTION, '0,
			u2hps_pkg::SPD_LOW);
		queue_request(u2hps_pkg::FN_CLR_FEATURE, 8'd8, u2hps_pkg::SEL_C_RESET, '0,
			u2hps_pkg::SPD_LOW);
		queue_request(u2hps_pkg::FN_CLR_FEATURE, 8'd8, 16'hFFFF, '0,
			u2hps_pkg::SPD_LOW);                                          // unknown selector
		queue_request(u2hps_pkg::FN_HUB_STATUS, '0, '0, 16'd3, u2hps_pkg::SPD_LOW);
		queue_request(u2hps_pkg::FN_HUB_FEATURE, 8'hFF, 16'hFFFF, 16'hFFFF,
			u2hps_pkg::SPD_SUPER);
		queue_request(u2hps_pkg::FN_CANCEL_POLL, '0, '0, '0, u2hps_pkg::SPD_LOW);
		queue_request(u2hps_pkg::FN_HUB_RESET, '0, '0, '0, u2hps_pkg::SPD_LOW);
		queue_request(u2hps_pkg::FN_FIND_FREE, '0, '0, '0, u2hps_pkg::SPD_FULL);
		queue_request(u2hps_pkg::FN_FIND_FREE, '0, '0, '0,
			u2hps_pkg::SPD_SUPER);                                        // finds none
		queue_request(4'hF, 8'd1, '0, '0, u2hps_pkg::SPD_LOW);        // unknown function
		wait_drained();

		// Random phases over several port counts, extremes included.
		for (int ph = 0; ph < 6; ph++) begin
			write_hub_ports(phase_counts[ph]);
			for (int k = 0; k < PHASE_ITEMS; k++)
				pending_requests.push_back(draw_request());
			if (ph == 0)
				want_long_hold = 1'b1;   // fill the result queue, back up the input
			steady = (ph == 3);          // one phase with no gaps on either side
			wait_drained();
			steady = 1'b0;
		end

		if (mismatches == 0)
			$display("usb2_hub_port_status_engine_top: match");
		else
			$display("usb2_hub_port_status_engine_top: mismatch");
		$finish;
	end

endmodule
